// ----- rtl/idc_pkg.sv -----
// ----------------------------------------------------------------------------
// idc_pkg
// Shared types, constants and the constant period table of the duty cycler.
// ----------------------------------------------------------------------------
`default_nettype none

package idc_pkg;

   localparam int FRAC_BITS   = 16;              // Q1.16 ratios
   localparam int Q_W         = FRAC_BITS + 1;   // holds 1.0 exactly
   localparam int IDX_W       = 5;               // table index width
   localparam int CNT_W       = 4;               // phase counters, max 9
   localparam int PE_W        = 8;               // periods_elapsed width
   localparam int TAB_MAX     = 24;              // entries in the table
   localparam int TAB_ENTRIES = 24;              // default used length

   localparam logic [Q_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

   // input kinds
   localparam logic REQ_TICK   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // register indexes
   localparam logic CSR_TARGET_UTIL = 1'b0;
   localparam logic CSR_RATIO_MODE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_STEP,
      ST_CHECK,
      ST_SEARCH
   } state_type;

   // command to the phase counter store
   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic             clr_one;
      logic             clr_all;
      logic             phase;
      logic [CNT_W-1:0] wr_data;
   } cnt_cmd_type;

   function automatic logic [CNT_W-1:0] tab_idle(input logic [IDX_W-1:0] idx);
      logic [CNT_W-1:0] v;
      case (idx)
         5'd0:    v = 4'd0;
         5'd1:    v = 4'd1;
         5'd2:    v = 4'd1;
         5'd3:    v = 4'd1;
         5'd4:    v = 4'd1;
         5'd5:    v = 4'd1;
         5'd6:    v = 4'd1;
         5'd7:    v = 4'd2;
         5'd8:    v = 4'd1;
         5'd9:    v = 4'd2;
         5'd10:   v = 4'd1;
         5'd11:   v = 4'd2;
         5'd12:   v = 4'd1;
         5'd13:   v = 4'd3;
         5'd14:   v = 4'd2;
         5'd15:   v = 4'd5;
         5'd16:   v = 4'd3;
         5'd17:   v = 4'd7;
         5'd18:   v = 4'd4;
         5'd19:   v = 4'd5;
         5'd20:   v = 4'd6;
         5'd21:   v = 4'd7;
         5'd22:   v = 4'd8;
         5'd23:   v = 4'd9;
         default: v = 4'd0;
      endcase
      return v;
   endfunction

   function automatic logic [CNT_W-1:0] tab_run(input logic [IDX_W-1:0] idx);
      logic [CNT_W-1:0] v;
      case (idx)
         5'd0:    v = 4'd1;
         5'd1:    v = 4'd9;
         5'd2:    v = 4'd8;
         5'd3:    v = 4'd7;
         5'd4:    v = 4'd6;
         5'd5:    v = 4'd5;
         5'd6:    v = 4'd4;
         5'd7:    v = 4'd7;
         5'd8:    v = 4'd3;
         5'd9:    v = 4'd5;
         5'd10:   v = 4'd2;
         5'd11:   v = 4'd3;
         5'd12:   v = 4'd1;
         5'd13:   v = 4'd2;
         5'd14:   v = 4'd1;
         5'd15:   v = 4'd2;
         5'd16:   v = 4'd1;
         5'd17:   v = 4'd2;
         5'd18:   v = 4'd1;
         5'd19:   v = 4'd1;
         5'd20:   v = 4'd1;
         5'd21:   v = 4'd1;
         5'd22:   v = 4'd1;
         5'd23:   v = 4'd1;
         default: v = 4'd1;
      endcase
      return v;
   endfunction

   // run / (idle + run), rounded to nearest, Q1.16
   function automatic logic [Q_W-1:0] tab_ratio(input logic [IDX_W-1:0] idx);
      logic [Q_W-1:0] v;
      case (idx)
         5'd0:    v = 17'd65536;
         5'd1:    v = 17'd58982;
         5'd2:    v = 17'd58254;
         5'd3:    v = 17'd57344;
         5'd4:    v = 17'd56174;
         5'd5:    v = 17'd54613;
         5'd6:    v = 17'd52429;
         5'd7:    v = 17'd50972;
         5'd8:    v = 17'd49152;
         5'd9:    v = 17'd46811;
         5'd10:   v = 17'd43691;
         5'd11:   v = 17'd39322;
         5'd12:   v = 17'd32768;
         5'd13:   v = 17'd26214;
         5'd14:   v = 17'd21845;
         5'd15:   v = 17'd18725;
         5'd16:   v = 17'd16384;
         5'd17:   v = 17'd14564;
         5'd18:   v = 17'd13107;
         5'd19:   v = 17'd10923;
         5'd20:   v = 17'd9362;
         5'd21:   v = 17'd8192;
         5'd22:   v = 17'd7282;
         5'd23:   v = 17'd6554;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   function automatic logic [Q_W-1:0] clamp_one(input logic [Q_W-1:0] v);
      return (v > ONE_Q) ? ONE_Q : v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/idc_phase_store.sv -----
// ----------------------------------------------------------------------------
// idc_phase_store
// Two-entry memory of phase down-counters, one per phase, with valid bits.
// An entry that is not valid reads with rd_valid low; the duty cycler then uses its reload value from the table.
// ----------------------------------------------------------------------------
`default_nettype none

module idc_phase_store (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire idc_pkg::cnt_cmd_type      cmd,
   output logic [idc_pkg::CNT_W-1:0]      rd_data,
   output logic                           rd_valid
);

   logic [idc_pkg::CNT_W-1:0] mem [2];
   logic [idc_pkg::CNT_W-1:0] rd_data_ff;
   logic                      rd_valid_ff;
   logic [1:0]                valid_ff;

   // reads and writes of one item never overlap, so no forwarding
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.phase] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.phase];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 2'b00;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[cmd.phase];
         end
         if (cmd.clr_all) begin
            valid_ff <= 2'b00;
         end else if (cmd.clr_one) begin
            valid_ff[cmd.phase] <= 1'b0;
         end else if (cmd.wr_en) begin
            valid_ff[cmd.phase] <= 1'b1;
         end
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/idc_ratio_search.sv -----
// ----------------------------------------------------------------------------
// idc_ratio_search
// Nearest-ratio search, one table entry per cycle; ties keep the lower index.
// ----------------------------------------------------------------------------
`default_nettype none

module idc_ratio_search #(
   parameter int TAB_LEN = idc_pkg::TAB_ENTRIES
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [idc_pkg::Q_W-1:0]   target,
   output logic                           done,
   output logic [idc_pkg::IDX_W-1:0]      best
);

   localparam logic [idc_pkg::IDX_W-1:0] LAST = idc_pkg::IDX_W'(TAB_LEN - 1);

   logic                      busy_ff;
   logic                      done_ff;
   logic [idc_pkg::IDX_W-1:0] idx_ff;
   logic [idc_pkg::IDX_W-1:0] best_ff;
   logic [idc_pkg::Q_W-1:0]   err_ff;
   logic [idc_pkg::Q_W-1:0]   tgt_ff;
   logic [idc_pkg::Q_W-1:0]   ratio;
   logic [idc_pkg::Q_W-1:0]   err;

   always_comb begin
      ratio = idc_pkg::tab_ratio(idx_ff);
      err   = (tgt_ff > ratio) ? (tgt_ff - ratio) : (ratio - tgt_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && idx_ff == LAST) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         idx_ff <= '0;
         best_ff <= '0;
         err_ff <= '1;   // above any distance, so entry 0 is always taken
         tgt_ff <= target;
      end else if (busy_ff) begin
         if (err < err_ff) begin
            err_ff  <= err;
            best_ff <= idx_ff;
         end
         if (idx_ff != LAST) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign best = best_ff;

endmodule

`default_nettype wire

// ----- rtl/idle_injection_duty_cycler.sv -----
// A tick passes through ST_TICK, a utilization sample through ST_STEP and ST_CHECK,
// a ratio sample through ST_SEARCH over TABLE_ENTRIES (at most 24) entries;
// rsp_tvalid is registered. One item at a time: the next is accepted only after
// the last result is registered; a waiting result holds the next item only at
// its last step. Phase counters sit in a 2-entry memory with a registered read.
// Synchronous reset: running, table entry 0, target 1.0.
// ----------------------------------------------------------------------------
// idle_injection_duty_cycler
// Runs or idles a task on a duty cycle picked from a constant period table.
// ----------------------------------------------------------------------------
`default_nettype none

module idle_injection_duty_cycler #(
   parameter int TABLE_ENTRIES = idc_pkg::TAB_ENTRIES
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // configuration
   input  wire logic                      csr_wen,
   input  wire logic                      csr_index,
   input  wire logic [idc_pkg::Q_W-1:0]   csr_wdata,
   // items in
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [31:0]               req_tdata,  // periods_elapsed, measured_util
   input  wire logic                      req_tuser,  // req_type
   // results out
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [7:0]                     rsp_tdata   // task_running, state_changed,
                                                      // table_index
);

   localparam int TAB_LEN = (TABLE_ENTRIES < idc_pkg::TAB_MAX) ?
                            TABLE_ENTRIES : idc_pkg::TAB_MAX;
   localparam logic [idc_pkg::IDX_W-1:0] LAST = idc_pkg::IDX_W'(TAB_LEN - 1);

   idc_pkg::state_type        state_ff, state_in;

   logic [idc_pkg::Q_W-1:0]   target_util_ff;
   logic                      ratio_mode_ff;

   logic                      phase_ff, phase_in;
   logic [idc_pkg::IDX_W-1:0] pos_ff, pos_in;
   logic [idc_pkg::PE_W-1:0]  pe_ff;
   logic [idc_pkg::Q_W-1:0]   meas_ff;
   logic [idc_pkg::IDX_W-1:0] np_ff, np_in;
   logic [idc_pkg::Q_W:0]     absd2_ff, absd2_in;   // twice |measured - target|

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_run_ff, rsp_run_in;
   logic                      rsp_chg_ff, rsp_chg_in;
   logic [idc_pkg::IDX_W-1:0] rsp_idx_ff, rsp_idx_in;

   idc_pkg::cnt_cmd_type      cmd;
   logic [idc_pkg::CNT_W-1:0] cnt_rd;
   logic                      cnt_valid;

   logic                      srch_start;
   logic                      srch_done;
   logic [idc_pkg::IDX_W-1:0] srch_best;

   logic                      accept;
   logic                      out_free;
   logic                      finish;
   logic [idc_pkg::Q_W-1:0]   tgt;
   logic [idc_pkg::Q_W-1:0]   meas;
   logic [idc_pkg::CNT_W-1:0] idle_rl;
   logic [idc_pkg::CNT_W-1:0] run_rl;
   logic [idc_pkg::CNT_W-1:0] cur_left;
   logic [idc_pkg::Q_W-1:0]   r_new;
   logic [idc_pkg::Q_W-1:0]   r_old;
   logic [idc_pkg::Q_W-1:0]   r_diff;
   logic [idc_pkg::IDX_W-1:0] new_pos;

   idc_phase_store u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_data  (cnt_rd),
      .rd_valid (cnt_valid)
   );

   idc_ratio_search #(
      .TAB_LEN (TAB_LEN)
   ) u_search (
      .clock  (clock),
      .reset  (reset),
      .start  (srch_start),
      .target (tgt),
      .done   (srch_done),
      .best   (srch_best)
   );

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      tgt      = idc_pkg::clamp_one(target_util_ff);
      meas     = idc_pkg::clamp_one(meas_ff);
      idle_rl  = idc_pkg::tab_idle(pos_ff);
      run_rl   = idc_pkg::tab_run(pos_ff);
      cur_left = cnt_valid ? cnt_rd : (phase_ff ? run_rl : idle_rl);
      r_new    = idc_pkg::tab_ratio(np_ff);
      r_old    = idc_pkg::tab_ratio(pos_ff);
      r_diff   = (r_new > r_old) ? (r_new - r_old) : (r_old - r_new);
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      np_in        = np_ff;
      absd2_in     = absd2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_run_in   = rsp_run_ff;
      rsp_chg_in   = rsp_chg_ff;
      rsp_idx_in   = rsp_idx_ff;
      cmd          = '0;
      cmd.phase    = phase_ff;
      srch_start   = 1'b0;
      req_tready   = 1'b0;
      finish       = 1'b0;
      new_pos      = pos_ff;

      case (state_ff)
         idc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == idc_pkg::REQ_TICK) begin
                  cmd.rd_en = 1'b1;
                  state_in  = idc_pkg::ST_TICK;
               end else if (!ratio_mode_ff) begin
                  state_in = idc_pkg::ST_STEP;
               end else begin
                  srch_start = 1'b1;
                  state_in   = idc_pkg::ST_SEARCH;
               end
            end
         end

         idc_pkg::ST_TICK: begin
            if (out_free) begin
               finish = 1'b1;
               if (tgt == idc_pkg::ONE_Q) begin
                  phase_in = 1'b1;
               end else if (tgt == '0) begin
                  phase_in = 1'b0;
               end else if (idle_rl == '0) begin
                  phase_in = 1'b1;   // never sleeps
               end else if ({{(idc_pkg::PE_W-idc_pkg::CNT_W){1'b0}}, cur_left} <= pe_ff) begin
                  // phase ends: toggle, counter back to its reload value
                  phase_in    = !phase_ff;
                  cmd.clr_one = 1'b1;
               end else begin
                  cmd.wr_en   = 1'b1;
                  cmd.wr_data = cur_left - pe_ff[idc_pkg::CNT_W-1:0];
               end
            end
         end

         idc_pkg::ST_STEP: begin
            if (meas > tgt) begin
               np_in    = (pos_ff < LAST) ? pos_ff + 1'b1 : pos_ff;
               absd2_in = {meas - tgt, 1'b0};
            end else begin
               np_in    = (meas < tgt && pos_ff != '0) ? pos_ff - 1'b1 : pos_ff;
               absd2_in = {tgt - meas, 1'b0};
            end
            state_in = idc_pkg::ST_CHECK;
         end

         idc_pkg::ST_CHECK: begin
            // hysteresis: step only if the gap is at least half the ratio step
            new_pos = (absd2_ff < {1'b0, r_diff}) ? pos_ff : np_ff;
            if (out_free) begin
               finish = 1'b1;
            end
         end

         idc_pkg::ST_SEARCH: begin
            new_pos = srch_best;
            if (srch_done && out_free) begin
               finish = 1'b1;
            end
         end

         default: begin
            state_in = idc_pkg::ST_IDLE;
         end
      endcase

      if (finish) begin
         if (new_pos != pos_ff) begin
            pos_in      = new_pos;
            cmd.clr_all = 1'b1;
         end
         rsp_valid_in = 1'b1;
         rsp_run_in   = phase_in;
         rsp_chg_in   = phase_in != phase_ff;
         rsp_idx_in   = pos_in;
         state_in     = idc_pkg::ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= idc_pkg::ST_IDLE;
         target_util_ff <= idc_pkg::ONE_Q;
         ratio_mode_ff  <= 1'b0;
         phase_ff       <= 1'b1;
         pos_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            case (csr_index)
               idc_pkg::CSR_TARGET_UTIL: target_util_ff <= csr_wdata;
               idc_pkg::CSR_RATIO_MODE:  ratio_mode_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pe_ff   <= req_tdata[idc_pkg::PE_W-1:0];
         meas_ff <= req_tdata[idc_pkg::PE_W +: idc_pkg::Q_W];
      end
      np_ff      <= np_in;
      absd2_ff   <= absd2_in;
      rsp_run_ff <= rsp_run_in;
      rsp_chg_ff <= rsp_chg_in;
      rsp_idx_ff <= rsp_idx_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_idx_ff, rsp_chg_ff, rsp_run_ff};

endmodule

`default_nettype wire

// ----- test/idle_injection_duty_cycler_tb.sv -----
// ----------------------------------------------------------------------------
// idle_injection_duty_cycler_tb
// Drives tick and sample items through the duty cycler under several target
// and mode settings, predicts each run/idle result in a scoreboard and
// checks every result field against it, with random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module idle_injection_duty_cycler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 30;
   localparam int SETTINGS_RAND  = 16;
   localparam int ITEMS_PER_SET  = 50;

   typedef struct packed {
      logic [idc_pkg::IDX_W-1:0] index;
      logic                      changed;
      logic                      running;
   } duty_result_type;

   class duty_cycle_scoreboard;
      duty_result_type pending_results[$];
      int           fails;
      int           idle_counts[24];
      int           run_periods[24];
      logic [idc_pkg::Q_W-1:0] target_util;
      logic         ratio_mode;
      logic         run_phase;
      int           table_pos;
      int           run_reload;
      int           idle_reload;
      int           run_left;
      int           idle_left;

      function new();
         idle_counts  = '{0, 1, 1, 1, 1, 1, 1, 2, 1, 2, 1, 2,
                          1, 3, 2, 5, 3, 7, 4, 5, 6, 7, 8, 9};
         run_periods  = '{1, 9, 8, 7, 6, 5, 4, 7, 3, 5, 2, 3,
                          1, 2, 1, 2, 1, 2, 1, 1, 1, 1, 1, 1};
         fails       = 0;
         target_util = idc_pkg::ONE_Q;
         ratio_mode  = 1'b0;
         run_phase   = 1'b1;
         table_pos   = 0;
         run_reload  = 1;
         idle_reload = 0;
         run_left    = 1;
         idle_left   = 0;
      endfunction

      function int entry_ratio(int i);
         int tot;
         tot = idle_counts[i] + run_periods[i];
         return ((run_periods[i] << idc_pkg::FRAC_BITS) + tot / 2) / tot;
      endfunction

      function int sat_one(int v);
         return (v > int'(idc_pkg::ONE_Q)) ? int'(idc_pkg::ONE_Q) : v;
      endfunction

      function int mag(int v);
         return (v < 0) ? -v : v;
      endfunction

      function void move_to(int p);
         if (p != table_pos) begin
            table_pos   = p;
            run_reload  = run_periods[p];
            run_left    = run_reload;
            idle_reload = idle_counts[p];
            idle_left   = idle_reload;
         end
      endfunction

      function void apply_csr(logic idx, int value);
         if (idx == idc_pkg::CSR_TARGET_UTIL) target_util = value[idc_pkg::Q_W-1:0];
         else ratio_mode = value[0];
      endfunction

      function void note_item(logic kind, int pe, int mu);
         logic            prev;
         int              tgt;
         int              last;
         int              diff;
         int              np;
         int              best;
         int              err;
         int              e;
         duty_result_type want;
         prev = run_phase;
         tgt  = sat_one(int'(target_util));
         last = idc_pkg::TAB_MAX - 1;
         if (kind == idc_pkg::REQ_TICK) begin
            if (tgt == int'(idc_pkg::ONE_Q)) run_phase = 1'b1;
            else if (tgt == 0) run_phase = 1'b0;
            else if (idle_reload == 0) run_phase = 1'b1;   // entry never sleeps
            else if (run_phase) begin
               run_left -= pe;
               if (run_left <= 0) begin
                  run_phase = 1'b0;
                  run_left  = run_reload;
               end
            end else begin
               idle_left -= pe;
               if (idle_left <= 0) begin
                  run_phase = 1'b1;
                  idle_left = idle_reload;
               end
            end
         end else if (!ratio_mode) begin
            diff = sat_one(mu) - tgt;
            np   = table_pos;
            if (diff > 0 && np < last) np++;
            else if (diff < 0 && np > 0) np--;
            // half-gap hysteresis
            if (2 * mag(diff) < mag(entry_ratio(np) - entry_ratio(table_pos)))
               np = table_pos;
            move_to(np);
         end else begin
            best = 0;
            err  = mag(tgt - entry_ratio(0));
            for (int i = 1; i <= last; i++) begin
               e = mag(tgt - entry_ratio(i));
               if (e < err) begin
                  err  = e;
                  best = i;
               end
            end
            move_to(best);
         end
         want.running = run_phase;
         want.changed = (run_phase != prev);
         want.index   = table_pos[idc_pkg::IDX_W-1:0];
         pending_results = {pending_results, want};
      endfunction

      function void check_result(logic [7:0] data);
         duty_result_type got;
         duty_result_type want;
         got = data[6:0];
         if (pending_results.size() == 0) begin
            if (fails < 10)
               $display("%0t: result with nothing pending: run=%0b chg=%0b idx=%0d",
                        $realtime, got.running, got.changed, got.index);
            fails++;
            return;
         end
         want = pending_results.pop_front();
         if (got.running !== want.running || got.changed !== want.changed ||
             got.index !== want.index) begin
            if (fails < 10)
               $display("%0t: expected run=%0b chg=%0b idx=%0d, got run=%0b chg=%0b idx=%0d",
                        $realtime, want.running, want.changed, want.index,
                        got.running, got.changed, got.index);
            fails++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_wen;
   logic                    csr_index;
   logic [idc_pkg::Q_W-1:0] csr_wdata;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [31:0]             req_tdata;    // periods_elapsed, measured_util
   logic                    req_tuser;    // req_type
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [7:0]              rsp_tdata;    // task_running, state_changed, table_index

   duty_cycle_scoreboard sb = new();
   bit               idle_free = 1'b0;
   int               quiet_cycles = 0;
   int               rsp_stall_left = 0;

   idle_injection_duty_cycler dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // result side: random stall bursts, changed on the falling edge
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_tready = 1'b0;
         end else if (!idle_free && $urandom_range(0, 7) == 0) begin
            rsp_stall_left = $urandom_range(1, 16) - 1;
            rsp_tready     = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called on a falling edge, returns on a falling edge
   task automatic push_item(logic kind, int pe, int mu);
      int gap;
      if (!idle_free && $urandom_range(0, 3) == 0) begin
         gap        = $urandom_range(1, 16);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {7'd0, mu[idc_pkg::Q_W-1:0], pe[idc_pkg::PE_W-1:0]};
      do @(posedge clock); while (!req_tready);
      sb.note_item(kind, pe, mu);
      @(negedge clock);
   endtask

   // wait until the block has nothing left in hand
   task automatic settle();
      req_tvalid = 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic idx, int value);
      csr_wen   = 1'b1;
      csr_index = idx;
      csr_wdata = value[idc_pkg::Q_W-1:0];
      @(negedge clock);
      csr_wen   = 1'b0;
      sb.apply_csr(idx, value);
   endtask

   function automatic int pick_target();
      int k;
      k = $urandom_range(0, 22);
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0: return 0;
               1: return 1;
               2: return 65535;
               3: return 65536;
               default: return 131071;
            endcase
         end
         1: return $urandom_range(0, 131071);
         2: return sb.entry_ratio(k);
         3: return (sb.entry_ratio(k) + sb.entry_ratio(k + 1)) / 2;   // near ties
         default: return $urandom_range(1, 65535);
      endcase
   endfunction

   task automatic random_setting(int target, logic mode, int count);
      int bias;
      int tgt;
      int mu;
      int pe;
      write_csr(idc_pkg::CSR_TARGET_UTIL, target);
      write_csr(idc_pkg::CSR_RATIO_MODE, mode);
      bias = $urandom_range(0, 2);
      tgt  = (target > 65536) ? 65536 : target;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 6) begin
            pe = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, 10);
            push_item(idc_pkg::REQ_TICK, pe, $urandom_range(0, 131071));
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  mu = tgt + $urandom_range(0, 6000) - 3000;
                  if (mu < 0) mu = 0;
               end
               4, 5, 6:    mu = $urandom_range(0, 131071);
               default: begin
                  if (bias == 1) mu = $urandom_range(tgt, 131071);
                  else if (bias == 2) mu = $urandom_range(0, tgt);
                  else mu = tgt;
               end
            endcase
            push_item(idc_pkg::REQ_SAMPLE, $urandom_range(0, 255), mu);
         end
      end
      settle();
   endtask

   initial begin
      reset      = 1'b1;
      csr_wen    = 1'b0;
      csr_index  = 1'b0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = idc_pkg::REQ_TICK;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // reset settings: target 1.0, stepping mode
      push_item(idc_pkg::REQ_TICK, 1, 0);
      push_item(idc_pkg::REQ_TICK, 0, 131071);
      push_item(idc_pkg::REQ_TICK, 255, 0);
      push_item(idc_pkg::REQ_SAMPLE, 0, 0);
      push_item(idc_pkg::REQ_SAMPLE, 255, 131071);
      push_item(idc_pkg::REQ_SAMPLE, 0, 65536);
      settle();

      // half target: step down the table, count the phases
      write_csr(idc_pkg::CSR_TARGET_UTIL, 32768);
      push_item(idc_pkg::REQ_SAMPLE, 0, 131071);
      push_item(idc_pkg::REQ_SAMPLE, 0, 131071);
      push_item(idc_pkg::REQ_SAMPLE, 0, 131071);
      push_item(idc_pkg::REQ_TICK, 0, 0);
      push_item(idc_pkg::REQ_TICK, 255, 0);
      push_item(idc_pkg::REQ_TICK, 255, 0);
      push_item(idc_pkg::REQ_TICK, 1, 0);
      push_item(idc_pkg::REQ_SAMPLE, 0, 0);
      push_item(idc_pkg::REQ_SAMPLE, 0, 32769);     // too small a gap to step
      settle();

      // zero target forces idle
      write_csr(idc_pkg::CSR_TARGET_UTIL, 0);
      push_item(idc_pkg::REQ_TICK, 5, 0);
      push_item(idc_pkg::REQ_SAMPLE, 0, 0);
      settle();

      // nearest-ratio search; midway between first two entries goes low
      write_csr(idc_pkg::CSR_RATIO_MODE, 1);
      write_csr(idc_pkg::CSR_TARGET_UTIL, 62259);
      push_item(idc_pkg::REQ_SAMPLE, 0, 0);
      push_item(idc_pkg::REQ_TICK, 3, 0);
      settle();
      write_csr(idc_pkg::CSR_TARGET_UTIL, 6554);
      push_item(idc_pkg::REQ_SAMPLE, 0, 0);
      push_item(idc_pkg::REQ_TICK, 9, 0);
      push_item(idc_pkg::REQ_TICK, 9, 0);
      push_item(idc_pkg::REQ_TICK, 1, 0);
      settle();
      write_csr(idc_pkg::CSR_TARGET_UTIL, 131071);
      push_item(idc_pkg::REQ_SAMPLE, 0, 131071);
      push_item(idc_pkg::REQ_TICK, 2, 0);
      settle();

      for (int s = 0; s < SETTINGS_RAND; s++) begin
         if (s >= SETTINGS_RAND - 3) idle_free = 1'b1;
         random_setting(pick_target(), 1'($urandom_range(0, 1)), ITEMS_PER_SET);
      end

      settle();
      if (sb.fails == 0 && sb.pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
